// File: design/crc8_line_frame_checker_defines.svh
// Assertion macros shared by the CRC-8 line frame checker RTL.
// No dependencies; included by the files that carry assertions.
`ifndef CRC8_LINE_FRAME_CHECKER_DEFINES_SVH
`define CRC8_LINE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CRC8LFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("crc8lfc: implication check failed");

// Next-cycle implication, checked out of reset.
`define CRC8LFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("crc8lfc: next-cycle check failed");

`endif

// File: design/crc8lfc_pkg.sv
// Package for the CRC-8 line frame checker: byte codes, status codes,
// the verdict struct and the CRC-8 / hex digit helpers. No dependencies.
`timescale 1ns / 1ps

package crc8lfc_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h07;
  localparam logic [7:0]  CRC_INIT    = 8'h00;
  localparam logic [15:0] LIMIT_RESET = 16'd512;
  localparam logic [7:0]  SEP_BYTE    = 8'h7C;
  localparam logic [7:0]  LF_BYTE     = 8'h0A;
  localparam logic [7:0]  CR_BYTE     = 8'h0D;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SUFFIX = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] payload_length;
    logic [7:0]  computed_crc;
    logic [7:0]  received_crc;
  } verdict_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      h.value = b[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: design/crc8lfc_in_stage.sv
// Input register for received bytes with valid/ready handshake.
// Depends on nothing; feeds crc8lfc_frame.
`timescale 1ns / 1ps

module crc8lfc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       advance_i,
  output logic       fire_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;

  assign in_ready_o = !vld_q || advance_i;
  assign fire_o     = vld_q && advance_i;
  assign byte_o     = byte_q;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_value_i;
    end
  end

endmodule

// File: design/crc8lfc_frame.sv
// Line state, running CRC-8, hex suffix parse and verdict for one beat.
// Uses crc8lfc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "crc8_line_frame_checker_defines.svh"

module crc8lfc_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            byte_i,
  input  logic [15:0]           line_limit_i,
  output logic                  res_valid_o,
  output crc8lfc_pkg::verdict_t res_o
);

  logic [7:0]  crc_q, crc_d;
  logic [15:0] len_q, len_d;
  logic        sep_q, sep_d;
  logic [7:0]  crc_sep_q, crc_sep_d;
  logic [15:0] len_sep_q, len_sep_d;
  logic [7:0]  suf_q, suf_d;
  logic        stop_q, stop_d;

  crc8lfc_pkg::hex_t hex;
  logic              res_vld;
  logic              clear;
  logic [16:0]       len_sep_inc;

  assign hex         = crc8lfc_pkg::hex_digit(byte_i);
  assign len_sep_inc = {1'b0, len_sep_q} + 17'd1;

  always_comb begin
    crc_d     = crc_q;
    len_d     = len_q;
    sep_d     = sep_q;
    crc_sep_d = crc_sep_q;
    len_sep_d = len_sep_q;
    suf_d     = suf_q;
    stop_d    = stop_q;
    res_vld   = 1'b0;
    clear     = 1'b0;
    res_o     = '0;
    if (byte_i == crc8lfc_pkg::CR_BYTE) begin
      res_vld = 1'b0;
    end else if (byte_i == crc8lfc_pkg::LF_BYTE) begin
      if (len_q != '0) begin
        res_vld = 1'b1;
        clear   = 1'b1;
        if (!sep_q) begin
          res_o.status = crc8lfc_pkg::ST_NO_SUFFIX;
        end else if ({1'b0, len_q} == len_sep_inc) begin
          res_o.status         = crc8lfc_pkg::ST_NO_SUFFIX;
          res_o.payload_length = len_sep_q;
          res_o.computed_crc   = crc_sep_q;
        end else begin
          res_o.status = (crc_sep_q == suf_q) ? crc8lfc_pkg::ST_OK
                                              : crc8lfc_pkg::ST_MISMATCH;
          res_o.payload_length = len_sep_q;
          res_o.computed_crc   = crc_sep_q;
          res_o.received_crc   = suf_q;
        end
      end
    end else if (len_q >= line_limit_i) begin
      res_vld      = 1'b1;
      clear        = 1'b1;
      res_o.status = crc8lfc_pkg::ST_OVERFLOW;
    end else begin
      if (byte_i == crc8lfc_pkg::SEP_BYTE) begin
        sep_d     = 1'b1;
        crc_sep_d = crc_q;
        len_sep_d = len_q;
        suf_d     = '0;
        stop_d    = 1'b0;
      end else if (sep_q && !stop_q) begin
        if (hex.valid) begin
          suf_d = {suf_q[3:0], hex.value};
        end else begin
          stop_d = 1'b1;
        end
      end
      crc_d = crc8lfc_pkg::crc_update(crc_q, byte_i);
      len_d = len_q + 16'd1;
    end
    if (clear) begin
      crc_d     = crc8lfc_pkg::CRC_INIT;
      len_d     = '0;
      sep_d     = 1'b0;
      crc_sep_d = '0;
      len_sep_d = '0;
      suf_d     = '0;
      stop_d    = 1'b0;
    end
  end

  assign res_valid_o = fire_i && res_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= crc8lfc_pkg::CRC_INIT;
      len_q     <= '0;
      sep_q     <= 1'b0;
      crc_sep_q <= '0;
      len_sep_q <= '0;
      suf_q     <= '0;
      stop_q    <= 1'b0;
    end else if (fire_i) begin
      crc_q     <= crc_d;
      len_q     <= len_d;
      sep_q     <= sep_d;
      crc_sep_q <= crc_sep_d;
      len_sep_q <= len_sep_d;
      suf_q     <= suf_d;
      stop_q    <= stop_d;
    end
  end

  `CRC8LFC_ASSERT_IMP(a_nosep_clean, clk_i, rst_ni, !sep_q, len_sep_q == '0 && crc_sep_q == '0 && !stop_q)
  `CRC8LFC_ASSERT_IMP(a_sep_inside, clk_i, rst_ni, sep_q, len_sep_q < len_q)
  `CRC8LFC_ASSERT_NXT(a_verdict_clears, clk_i, rst_ni, res_valid_o, len_q == '0 && !sep_q)

endmodule

// File: design/crc8_line_frame_checker.sv
// CRC-8 line frame checker: one byte a cycle; each input beat is registered in the
// input register, then goes through verdict logic into the result register.
// Throughput 1 byte per cycle; only the result register backpressure stalls it.
// Reset (async, active low) clears all line state and sets line_limit to 512.
// Top level; uses crc8lfc_pkg, crc8lfc_in_stage, crc8lfc_frame and the
// assertion macros header.
`timescale 1ns / 1ps
`include "crc8_line_frame_checker_defines.svh"

module crc8_line_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        line_limit_we_i,
  input  logic [15:0] line_limit_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] payload_length_o,
  output logic [7:0]  computed_crc_o,
  output logic [7:0]  received_crc_o
);

  logic [15:0]           limit_q;
  logic                  advance;
  logic                  fire;
  logic [7:0]            byte_q;
  logic                  res_vld;
  crc8lfc_pkg::verdict_t res;
  logic                  out_vld_q, out_vld_d;
  crc8lfc_pkg::verdict_t out_q;

  assign advance = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= crc8lfc_pkg::LIMIT_RESET;
    end else if (line_limit_we_i) begin
      limit_q <= line_limit_i;
    end
  end

  crc8lfc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .advance_i    (advance),
    .fire_o       (fire),
    .byte_o       (byte_q)
  );

  crc8lfc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .byte_i       (byte_q),
    .line_limit_i (limit_q),
    .res_valid_o  (res_vld),
    .res_o        (res)
  );

  assign out_vld_d = advance ? res_vld : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_q.status;
  assign payload_length_o = out_q.payload_length;
  assign computed_crc_o   = out_q.computed_crc;
  assign received_crc_o   = out_q.received_crc;

  `CRC8LFC_ASSERT_IMP(a_ovf_zero, clk_i, rst_ni, out_vld_q && out_q.status == crc8lfc_pkg::ST_OVERFLOW, out_q.payload_length == '0 && out_q.received_crc == '0)
  `CRC8LFC_ASSERT_IMP(a_res_only_on_fire, clk_i, rst_ni, res_vld, fire && advance)

endmodule

// File: test/tb_crc8_line_frame_checker.sv
`timescale 1ns / 1ps
// Testbench for crc8_line_frame_checker: directed and random byte streams are
// run under several line limits and every verdict beat is checked.
// Depends on crc8lfc_pkg and the crc8_line_frame_checker RTL.

module tb_crc8_line_frame_checker;

  class frame_scoreboard;
    logic [15:0]           limit;
    logic [7:0]            crc_run;
    logic [15:0]           len;
    logic                  sep_seen;
    logic [7:0]            crc_sep;
    logic [15:0]           len_sep;
    logic [7:0]            sfx;
    logic                  sfx_done;
    crc8lfc_pkg::verdict_t verdict_q[$];
    int unsigned           errors;
    int unsigned           status_count[4];

    function new();
      limit = crc8lfc_pkg::LIMIT_RESET;
      errors = 0;
      foreach (status_count[i]) status_count[i] = 0;
      clear_line();
    endfunction

    function void clear_line();
      crc_run  = crc8lfc_pkg::CRC_INIT;
      len      = '0;
      sep_seen = 1'b0;
      crc_sep  = '0;
      len_sep  = '0;
      sfx      = '0;
      sfx_done = 1'b0;
    endfunction

    // bit-serial, MSB first
    function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb  = crc[7] ^ b[i];
        crc = {crc[6:0], 1'b0} ^ (fb ? crc8lfc_pkg::CRC_POLY : 8'h00);
      end
      return crc;
    endfunction

    function int hex_nibble(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
      if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
      if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
      return -1;
    endfunction

    function void note_byte(logic [7:0] b);
      crc8lfc_pkg::verdict_t v;
      int d;
      v = '0;
      if (b == crc8lfc_pkg::CR_BYTE) return;
      if (b == crc8lfc_pkg::LF_BYTE) begin
        if (len == 0) return;
        v.status = crc8lfc_pkg::ST_NO_SUFFIX;
        if (sep_seen) begin
          v.payload_length = len_sep;
          v.computed_crc = crc_sep;
          if (len != len_sep + 16'd1) begin
            v.received_crc = sfx;
            v.status = (crc_sep == sfx) ? crc8lfc_pkg::ST_OK : crc8lfc_pkg::ST_MISMATCH;
          end
        end
        verdict_q.push_back(v);
        clear_line();
        return;
      end
      if (len >= limit) begin
        v.status = crc8lfc_pkg::ST_OVERFLOW;
        verdict_q.push_back(v);
        clear_line();
        return;
      end
      if (b == crc8lfc_pkg::SEP_BYTE) begin
        sep_seen = 1'b1;
        crc_sep  = crc_run;
        len_sep  = len;
        sfx      = '0;
        sfx_done = 1'b0;
      end else if (sep_seen && !sfx_done) begin
        d = hex_nibble(b);
        if (d < 0) sfx_done = 1'b1;
        else sfx = {sfx[3:0], d[3:0]};
      end
      crc_run = crc_step(crc_run, b);
      len = len + 16'd1;
    endfunction

    function void check_verdict(logic [1:0] st, logic [15:0] pl, logic [7:0] cc,
                                logic [7:0] rc);
      crc8lfc_pkg::verdict_t e;
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict: status %0d length %0d crc %02h/%02h", st, pl, cc, rc);
        errors++;
        return;
      end
      e = verdict_q.pop_front();
      status_count[e.status]++;
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (pl !== e.payload_length) begin
        $error("payload_length: expected %0d, got %0d", e.payload_length, pl);
        errors++;
      end
      if (cc !== e.computed_crc) begin
        $error("computed_crc: expected %02h, got %02h", e.computed_crc, cc);
        errors++;
      end
      if (rc !== e.received_crc) begin
        $error("received_crc: expected %02h, got %02h", e.received_crc, rc);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        line_limit_we_i;
  logic [15:0] line_limit_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] payload_length_o;
  logic [7:0]  computed_crc_o;
  logic [7:0]  received_crc_o;

  frame_scoreboard sb;
  bit              quiet;
  bit              hold_req;
  int unsigned     bytes_sent;
  int unsigned     limit_writes;

  crc8_line_frame_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .line_limit_we_i  (line_limit_we_i),
    .line_limit_i     (line_limit_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_value_i     (byte_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .payload_length_o (payload_length_o),
    .computed_crc_o   (computed_crc_o),
    .received_crc_o   (received_crc_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 10) return 8'h30 + nib;
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = (!quiet && $urandom_range(99) < 30) ? $urandom_range(2, 1) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_framed_line(int unsigned min_len, int unsigned max_len);
    logic [7:0]  c;
    logic [7:0]  b;
    logic [7:0]  val;
    int unsigned n;
    int unsigned ndig;
    c = crc8lfc_pkg::CRC_INIT;
    n = $urandom_range(max_len, min_len);
    for (int unsigned i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (b == crc8lfc_pkg::LF_BYTE || b == crc8lfc_pkg::SEP_BYTE) b ^= 8'h40;
      if (b != crc8lfc_pkg::CR_BYTE) c = sb.crc_step(c, b);
      send_byte(b);
    end
    send_byte(crc8lfc_pkg::SEP_BYTE);
    val = c;
    if ($urandom_range(99) < 20) val ^= 8'($urandom_range(255, 1));
    if ($urandom_range(99) >= 5) begin
      ndig = ($urandom_range(99) < 15) ? $urandom_range(4, 1) : 0;
      repeat (ndig) send_byte(hex_char(4'($urandom_range(15))));
      if (ndig != 0 || val > 8'h0F || $urandom_range(1)) send_byte(hex_char(val[7:4]));
      send_byte(hex_char(val[3:0]));
    end
    if ($urandom_range(99) < 15) begin
      send_byte(8'($urandom_range(8'h7B, 8'h67)));
      b = 8'($urandom_range(255));
      if (b == crc8lfc_pkg::LF_BYTE) b = 8'h00;
      send_byte(b);
    end
    if ($urandom_range(99) < 20) send_byte(crc8lfc_pkg::CR_BYTE);
    send_byte(crc8lfc_pkg::LF_BYTE);
  endtask

  task automatic send_noise_line();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  b;
    n = $urandom_range(12);
    repeat (n) begin
      pick = $urandom_range(7);
      case (pick)
        0:       b = crc8lfc_pkg::LF_BYTE;
        1:       b = crc8lfc_pkg::CR_BYTE;
        2:       b = crc8lfc_pkg::SEP_BYTE;
        3, 4:    b = hex_char(4'($urandom_range(15)));
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b);
    end
    if ($urandom_range(3) != 0) send_byte(crc8lfc_pkg::LF_BYTE);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [15:0] v);
    drain();
    line_limit_we_i <= 1'b1;
    line_limit_i    <= v;
    @(posedge clk_i);
    sb.limit = v;
    line_limit_we_i <= 1'b0;
    limit_writes++;
  endtask

  task automatic run_phase(int unsigned budget, int unsigned max_len, int unsigned long_len);
    int unsigned stop_at;
    stop_at = bytes_sent + budget;
    if (long_len != 0) send_framed_line(long_len, long_len);
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 75) send_framed_line(0, max_len);
      else send_noise_line();
    end
  endtask

  initial begin
    sb = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    byte_value_i    = '0;
    line_limit_we_i = 1'b0;
    line_limit_i    = crc8lfc_pkg::LIMIT_RESET;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    bytes_sent      = 0;
    limit_writes    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty line, CR, byte extremes without separator, empty and bad suffixes
    send_byte(crc8lfc_pkg::LF_BYTE);
    send_byte(crc8lfc_pkg::CR_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(crc8lfc_pkg::LF_BYTE);
    send_text("xy|\n");
    send_text("a|zz\n");
    send_text("q|12");
    send_byte(crc8lfc_pkg::CR_BYTE);
    send_text("3AbF\n");

    run_phase(230, 16, 520);
    set_limit(16'd1);
    run_phase(120, 4, 0);
    quiet = 1'b1;
    set_limit(16'hFFFF);
    run_phase(300, 24, 300);
    quiet = 1'b0;
    set_limit(16'($urandom_range(24, 2)));
    run_phase(120, 30, 0);
    set_limit(16'($urandom_range(24, 2)));
    hold_req = 1'b1;
    run_phase(150, 3, 0);
    set_limit(crc8lfc_pkg::LIMIT_RESET);
    run_phase(60, 40, 0);

    in_valid_i <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("covered %0d input beats over %0d limit writes; verdicts ok %0d, no suffix %0d,",
             bytes_sent, limit_writes, sb.status_count[crc8lfc_pkg::ST_OK],
             sb.status_count[crc8lfc_pkg::ST_NO_SUFFIX]);
    $display("  mismatch %0d, overflow %0d", sb.status_count[crc8lfc_pkg::ST_MISMATCH],
             sb.status_count[crc8lfc_pkg::ST_OVERFLOW]);
    if (sb.errors == 0) begin
      $display("tb_crc8_line_frame_checker: clean");
    end else begin
      $display("tb_crc8_line_frame_checker: errors");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    hold_left   = 0;
    hold_taken  = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_verdict(status_o, payload_length_o, computed_crc_o, received_crc_o);
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      out_ready_i <= (hold_left != 0) ? 1'b0 : (quiet || $urandom_range(99) >= 30);
    end
  end

  initial begin
    #2_000_000;
    $display("tb_crc8_line_frame_checker: errors");
    $finish;
  end

endmodule

// File: crc8_line_frame_checker.f
+incdir+design
design/crc8lfc_pkg.sv
design/crc8lfc_in_stage.sv
design/crc8lfc_frame.sv
design/crc8_line_frame_checker.sv
test/tb_crc8_line_frame_checker.sv
